// File: design/sge_pkg.sv
// Shared types, constants and helpers for the signed Golomb encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sge_pkg;

   // Default build parameters.
   localparam int DEF_VALUE_WIDTH  = 16;
   localparam int DEF_MAX_QUOTIENT = 256;

   // Divisor register width and its reset value.
   localparam int DIV_W = 16;
   localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(1);

   // Remainder bit count ranges 0..DIV_W.
   localparam int RBITS_W = $clog2(DIV_W + 1);

   // Quotient field wide enough for any MAX_QUOTIENT up to 511.
   localparam int QUO_W = 9;

   // Bit positions in a codeword: body plus sign plus padding stays below 1024.
   localparam int POS_W = 10;

   // Byte index inside one codeword.
   localparam int IDX_W = POS_W - 3;

   localparam int BYTE_W = 8;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic               neg;
      logic               ovf;
      logic [QUO_W-1:0]   quo;
      logic [DIV_W-1:0]   rem;
      logic [RBITS_W-1:0] rbits;
   } entry_type;

   // Number of remainder bits: smallest b with 2**b >= m, for m >= 1.
   function automatic logic [RBITS_W-1:0] rem_bits(input logic [DIV_W-1:0] m);
      logic [DIV_W-1:0]   mm1;
      logic [RBITS_W-1:0] b;
      mm1 = m - DIV_W'(1);
      b   = '0;
      for (int i = 0; i < DIV_W; i++) begin
         if (mm1[i]) begin
            b = RBITS_W'(i + 1);
         end
      end
      return b;
   endfunction

endpackage

// File: design/signed_golomb_encoder.sv
// Signed Golomb encoder, top level: divisor register, front, queue and back.
// Depends on sge_pkg, sge_front, sge_queue and sge_back.
//
// Usage:
//   req_valid/req_ready/req_sample take one signed sample per item.
//   rsp_valid/rsp_ready carry the codeword bytes, MSB first, with rsp_last on
//   the final byte and rsp_overflow on the single zero byte that replaces a
//   codeword whose quotient exceeds MAX_QUOTIENT.
//   csr_valid/csr_ready/csr_divisor write the Golomb parameter (0 acts as 1);
//   csr_ready is always high. Write it only while no item is in flight.
// Timing:
//   The front runs a restoring divider, one quotient bit per cycle; per item
//   it loads, takes VALUE_WIDTH steps and hands off before a new sample.
//   The back emits one byte per cycle while the receiver is ready,
//   ceil((q + 1 + b) / 8) + 1 bytes per codeword (one for an overflow), and
//   picks up a new item only after the last byte of the one before. A
//   two-entry queue lets both sides run at once; sustained rate is the slower
//   of the two.
// Reset clears the divisor to 1 and empties the queue and output stage.
// When the receiver stalls, the output byte holds, the back stops, the queue
// fills and then req_ready drops.
module signed_golomb_encoder
   import sge_pkg::*;
#(
   parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH,
   parameter int MAX_QUOTIENT = DEF_MAX_QUOTIENT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_code_byte,
   output logic                   rsp_last,
   output logic                   rsp_overflow,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [DIV_W-1:0]       csr_divisor
);

   logic [DIV_W-1:0] divisor_ff, divisor_in;
   logic             push, pop, full, empty;
   entry_type        push_entry, pop_entry;

   // Divisor register.
   assign csr_ready  = 1'b1;
   assign divisor_in = (csr_valid && csr_ready) ? csr_divisor : divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIV_RESET;
      end else begin
         divisor_ff <= divisor_in;
      end
   end

   sge_front #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .MAX_QUOTIENT (MAX_QUOTIENT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .divisor    (divisor_ff),
      .push       (push),
      .push_entry (push_entry),
      .full       (full)
   );

   sge_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (empty)
   );

   sge_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop           (pop),
      .pop_entry     (pop_entry),
      .empty         (empty),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

// File: design/sge_queue.sv
// Small FIFO of classified items between the front and the back.
// Depends on sge_pkg for the entry type and depth.
module sge_queue
   import sge_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem[rd_ptr_ff];

   // Pointer and fill-count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/sge_front.sv
// Front end: accepts a sample, forms its magnitude and divides it by the
// Golomb parameter one quotient bit per cycle. Depends on sge_pkg.
module sge_front
   import sge_pkg::*;
#(
   parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH,
   parameter int MAX_QUOTIENT = DEF_MAX_QUOTIENT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_sample,
   input  logic [DIV_W-1:0]       divisor,
   output logic                   push,
   output entry_type              push_entry,
   input  logic                   full
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   m_ff, m_in;
   logic [RBITS_W-1:0] rbits_ff, rbits_in;
   logic               neg_ff, neg_in;

   logic [DIV_W-1:0]   m_eff;
   logic [DIV_W:0]     trial;
   logic               fits;
   logic               ovf;

   // A zero divisor behaves as one.
   assign m_eff = (divisor == '0) ? DIV_RESET : divisor;

   // One restoring-division step.
   assign trial = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
   assign fits  = (trial >= {1'b0, m_ff});

   assign ovf = (32'(dvd_ff) > 32'(MAX_QUOTIENT));

   assign req_ready = (state_ff == F_IDLE);
   assign push      = (state_ff == F_PUSH);

   always_comb begin
      push_entry       = '0;
      push_entry.neg   = neg_ff;
      push_entry.ovf   = ovf;
      push_entry.quo   = QUO_W'(dvd_ff);
      push_entry.rem   = rem_ff;
      push_entry.rbits = rbits_ff;
   end

   // Sequencer: load, iterate the divider, then hand the item to the queue.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      m_in     = m_ff;
      rbits_in = rbits_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               neg_in   = req_sample[VALUE_WIDTH-1];
               dvd_in   = req_sample[VALUE_WIDTH-1] ? (~req_sample + VALUE_WIDTH'(1))
                                                    : req_sample;
               rem_in   = '0;
               m_in     = m_eff;
               rbits_in = rem_bits(m_eff);
               cnt_in   = CNT_W'(VALUE_WIDTH);
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            rem_in = fits ? DIV_W'(trial - {1'b0, m_ff}) : DIV_W'(trial);
            dvd_in = {dvd_ff[VALUE_WIDTH-2:0], fits};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      m_ff     <= m_in;
      rbits_ff <= rbits_in;
      neg_ff   <= neg_in;
   end

endmodule

// File: design/sge_back.sv
// Back end: takes classified items from the queue and emits each codeword
// one byte per cycle while the receiver keeps up, through a registered output stage. Depends on sge_pkg.
module sge_back
   import sge_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   output logic              pop,
   input  entry_type         pop_entry,
   input  logic              empty,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_code_byte,
   output logic              rsp_last,
   output logic              rsp_overflow
);

   logic              active_ff, active_in;
   entry_type         entry_ff, entry_in;
   logic [POS_W-1:0]  body_ff, body_in;
   logic [IDX_W-1:0]  last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              ovf_ff, ovf_in;

   logic              emit;
   logic              is_last;
   logic [BYTE_W-1:0] cur_byte;
   logic [POS_W-1:0]  quo_ext;
   logic [POS_W-1:0]  body_new;

   assign pop      = !active_ff && !empty;
   assign emit     = active_ff && (!rsp_valid_ff || rsp_ready);
   assign is_last  = entry_ff.ovf || (idx_ff == last_idx_ff);
   assign quo_ext  = POS_W'(entry_ff.quo);
   assign body_new = POS_W'(pop_entry.quo) + POS_W'(1) + POS_W'(pop_entry.rbits);

   // Bits of the current byte: sign, unary run, terminator, remainder, padding.
   always_comb begin
      logic [POS_W-1:0] p;
      logic [POS_W-1:0] diff;
      cur_byte = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         p    = {idx_ff, 3'(k)};
         diff = body_ff - p;
         if (p == '0) begin
            cur_byte[BYTE_W-1-k] = entry_ff.neg;
         end else if (p <= quo_ext) begin
            cur_byte[BYTE_W-1-k] = 1'b1;
         end else if (p > quo_ext + POS_W'(1) && p <= body_ff) begin
            cur_byte[BYTE_W-1-k] = entry_ff.rem[diff[RBITS_W-2:0]];
         end
      end
      if (entry_ff.ovf) begin
         cur_byte = '0;
      end
   end

   // Item load, byte stepping and output register.
   always_comb begin
      active_in    = active_ff;
      entry_in     = entry_ff;
      body_in      = body_ff;
      last_idx_in  = last_idx_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      ovf_in       = ovf_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         active_in   = 1'b1;
         entry_in    = pop_entry;
         body_in     = body_new;
         last_idx_in = IDX_W'((body_new + POS_W'(7)) >> 3);
         idx_in      = '0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = cur_byte;
         last_in      = is_last;
         ovf_in       = entry_ff.ovf;
         idx_in       = idx_ff + IDX_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      entry_ff    <= entry_in;
      body_ff     <= body_in;
      last_idx_ff <= last_idx_in;
      idx_ff      <= idx_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      ovf_ff      <= ovf_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_byte = byte_ff;
   assign rsp_last      = last_ff;
   assign rsp_overflow  = ovf_ff;

endmodule
